// File: hw/rtl/rpnc_pkg.sv
// Shared types and codes for the RPN stack calculator.
`default_nettype none

package rpnc_pkg;

	// Operation codes carried by a request.
	typedef enum logic [3:0] {
		OP_PUSH  = 4'd0,
		OP_NEG   = 4'd1,
		OP_DUP   = 4'd2,
		OP_SWAP  = 4'd3,
		OP_PEEK  = 4'd4,
		OP_CLEAR = 4'd5,
		OP_DUMP  = 4'd6,
		OP_ADD   = 4'd7,
		OP_SUB   = 4'd8,
		OP_MUL   = 4'd9,
		OP_DIV   = 4'd10
	} op_t;

	// Status codes reported with each result.
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_DIVZ = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	// Request payload.
	typedef struct packed {
		logic [3:0]         operation;
		logic signed [31:0] operand_value;
	} req_t;

	// Result payload.
	typedef struct packed {
		logic signed [31:0] result_value;
		logic               has_value;
		status_t            status;
		logic               last_of_run;
	} rsp_t;

	// Stack write address, relative to the entry count.
	typedef enum logic [1:0] {
		WA_N  = 2'd0,
		WA_N1 = 2'd1,
		WA_N2 = 2'd2
	} wr_addr_sel_t;

	// Stack write data source.
	typedef enum logic [2:0] {
		WD_VAL  = 3'd0,
		WD_NEG  = 3'd1,
		WD_TOP  = 3'd2,
		WD_SEC  = 3'd3,
		WD_SUM  = 3'd4,
		WD_DIFF = 3'd5,
		WD_UNIT = 3'd6
	} wr_data_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic         capture;
		logic         rd_en;
		logic         rd_walk;
		logic         wr_en;
		wr_addr_sel_t wr_addr;
		wr_data_sel_t wr_data;
		logic         cnt_inc;
		logic         cnt_dec;
		logic         cnt_clr;
		logic         walk_load;
		logic         walk_dec;
		logic         unit_start;
		logic         unit_div;
		logic         emit;
		logic         emit_has;
		status_t      emit_status;
		logic         emit_last;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic lt2;
		logic full;
		logic top_zero;
		logic walk_zero;
		logic unit_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/rpnc_muldiv.sv
// Iterative multiply and signed divide unit, one bit per cycle.
`default_nettype none

module rpnc_muldiv #(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic         is_div,
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic              done,
	output logic [W-1:0]      res
);

	localparam int CW = $clog2(W + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          div_q;
	logic          neg_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  y_q;
	logic [W-1:0]  rem_q;

	logic [W-1:0]  abs_a;
	logic [W-1:0]  abs_b;
	logic [W:0]    rem_sh;
	logic          ge;
	logic [W:0]    rem_nx;

	// Operand magnitudes for division; the most negative value maps onto itself.
	assign abs_a = a[W-1] ? ('0 - a) : a;
	assign abs_b = b[W-1] ? ('0 - b) : b;

	// Restoring division step: shift in the next dividend bit and try a subtract.
	assign rem_sh = {rem_q, x_q[W-1]};
	assign ge     = rem_sh >= {1'b0, y_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, y_q}) : rem_sh;

	// Control sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial result registers.
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			neg_q <= a[W-1] ^ b[W-1];
			acc_q <= '0;
			rem_q <= '0;
			x_q   <= is_div ? abs_a : a;
			y_q   <= is_div ? abs_b : b;
		end else if (run_q) begin
			if (div_q) begin
				rem_q <= rem_nx[W-1:0];
				x_q   <= {x_q[W-2:0], ge};
			end else begin
				if (y_q[0]) begin
					acc_q <= acc_q + x_q;
				end
				x_q <= {x_q[W-2:0], 1'b0};
				y_q <= {1'b0, y_q[W-1:1]};
			end
		end
	end

	// Quotient takes its sign at the end; the product is already in place.
	assign res  = div_q ? (neg_q ? ('0 - x_q) : x_q) : acc_q;
	assign done = done_q;

endmodule

`default_nettype wire

// File: hw/rtl/rpnc_datapath.sv
// Datapath of the RPN stack calculator: stack memory, count, adder and result register.
`default_nettype none

module rpnc_datapath #(
	parameter int STACK_DEPTH = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rpnc_pkg::req_t    req,
	input  wire rpnc_pkg::dp_cmd_t cmd,
	output rpnc_pkg::dp_stat_t     stat,
	output logic                   done,
	output rpnc_pkg::rsp_t         rsp
);

	import rpnc_pkg::*;

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];

	logic [CNT_W-1:0]       count_q;
	logic [ADDR_W-1:0]      walk_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [VALUE_WIDTH-1:0] rd_a_q;
	logic [VALUE_WIDTH-1:0] rd_b_q;
	logic                   done_q;
	rsp_t                   rsp_q;

	logic [CNT_W-1:0]       cnt_m1;
	logic [CNT_W-1:0]       cnt_m2;
	logic [ADDR_W-1:0]      addr_a;
	logic [ADDR_W-1:0]      wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic [VALUE_WIDTH-1:0] unit_res;
	logic                   unit_done;
	logic signed [63:0]     top_ext;

	// Addresses relative to the entry count.
	assign cnt_m1 = count_q - CNT_W'(1);
	assign cnt_m2 = count_q - CNT_W'(2);
	assign addr_a = cmd.rd_walk ? walk_q : cnt_m1[ADDR_W-1:0];

	always_comb begin
		case (cmd.wr_addr)
			WA_N:    wr_addr = count_q[ADDR_W-1:0];
			WA_N1:   wr_addr = cnt_m1[ADDR_W-1:0];
			WA_N2:   wr_addr = cnt_m2[ADDR_W-1:0];
			default: wr_addr = count_q[ADDR_W-1:0];
		endcase
	end

	// Write data: top is rd_a_q, the entry below it is rd_b_q.
	always_comb begin
		case (cmd.wr_data)
			WD_VAL:  wr_data = val_q;
			WD_NEG:  wr_data = '0 - rd_a_q;
			WD_TOP:  wr_data = rd_a_q;
			WD_SEC:  wr_data = rd_b_q;
			WD_SUM:  wr_data = rd_b_q + rd_a_q;
			WD_DIFF: wr_data = rd_b_q - rd_a_q;
			WD_UNIT: wr_data = unit_res;
			default: wr_data = val_q;
		endcase
	end

	// Stack memory with one write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_a_q <= stack_mem[addr_a];
			rd_b_q <= stack_mem[cnt_m2[ADDR_W-1:0]];
		end
	end

	// Request value, sign-extended or cut to the stack width.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			val_q <= VALUE_WIDTH'(64'(req.operand_value));
		end
	end

	// Entry count and dump walk pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			walk_q  <= '0;
		end else begin
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= cnt_m1;
			end
			if (cmd.walk_load) begin
				walk_q <= cnt_m1[ADDR_W-1:0];
			end else if (cmd.walk_dec) begin
				walk_q <= walk_q - ADDR_W'(1);
			end
		end
	end

	// Shared multiply and divide unit.
	rpnc_muldiv #(
		.W(VALUE_WIDTH)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.unit_start),
		.is_div (cmd.unit_div),
		.a      (rd_b_q),
		.b      (rd_a_q),
		.done   (unit_done),
		.res    (unit_res)
	);

	// Result register; the strobe lasts one cycle.
	assign top_ext = 64'(signed'(rd_a_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.result_value <= cmd.emit_has ? 32'(top_ext) : '0;
			rsp_q.has_value    <= cmd.emit_has;
			rsp_q.status       <= cmd.emit_status;
			rsp_q.last_of_run  <= cmd.emit_last;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// Status for the controller.
	assign stat.empty     = count_q == '0;
	assign stat.lt2       = count_q < CNT_W'(2);
	assign stat.full      = count_q == CNT_W'(STACK_DEPTH);
	assign stat.top_zero  = rd_a_q == '0;
	assign stat.walk_zero = walk_q == '0;
	assign stat.unit_done = unit_done;

	// The count stays within the stack.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("entry count beyond stack depth");

	// A growing write never lands on a full stack.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !stat.full)
		else $error("count increment on a full stack");

	// Two-operand results only replace two existing entries.
	a_dec_two: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> !stat.lt2)
		else $error("count decrement with fewer than two entries");

	// Result strobes are never back to back.
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe in two consecutive cycles");

endmodule

`default_nettype wire

// File: hw/rtl/rpnc_ctrl.sv
// Controller state machine of the RPN stack calculator.
`default_nettype none

module rpnc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [3:0]         operation,
	input  wire rpnc_pkg::dp_stat_t stat,
	output rpnc_pkg::dp_cmd_t       cmd,
	output logic                    busy
);

	import rpnc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_EXEC,
		S_SWAP2,
		S_ITER,
		S_DUMP_RD,
		S_DUMP_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	op_t    op_q;
	logic   busy_q;

	// Next state and datapath commands.
	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.emit_status = ST_OK;
		cmd.emit_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_FETCH;
				end
			end
			S_FETCH: begin
				cmd.rd_en = 1'b1;
				state_d   = S_EXEC;
			end
			S_EXEC: begin
				state_d  = S_IDLE;
				cmd.emit = 1'b1;
				case (op_q)
					OP_PUSH: begin
						if (stat.full) begin
							cmd.emit_status = ST_FULL;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_addr = WA_N;
							cmd.wr_data = WD_VAL;
							cmd.cnt_inc = 1'b1;
						end
					end
					OP_NEG: begin
						if (stat.empty) begin
							cmd.emit_status = ST_FEW;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_addr = WA_N1;
							cmd.wr_data = WD_NEG;
						end
					end
					OP_DUP: begin
						if (stat.empty) begin
							cmd.emit_status = ST_FEW;
						end else if (stat.full) begin
							cmd.emit_status = ST_FULL;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_addr = WA_N;
							cmd.wr_data = WD_TOP;
							cmd.cnt_inc = 1'b1;
						end
					end
					OP_SWAP: begin
						if (stat.lt2) begin
							cmd.emit_status = ST_FEW;
						end else begin
							cmd.emit    = 1'b0;
							cmd.wr_en   = 1'b1;
							cmd.wr_addr = WA_N1;
							cmd.wr_data = WD_SEC;
							state_d     = S_SWAP2;
						end
					end
					OP_PEEK: begin
						if (stat.empty) begin
							cmd.emit_status = ST_FEW;
						end else begin
							cmd.emit_has = 1'b1;
						end
					end
					OP_CLEAR: begin
						cmd.cnt_clr = 1'b1;
					end
					OP_DUMP: begin
						if (!stat.empty) begin
							cmd.emit      = 1'b0;
							cmd.walk_load = 1'b1;
							state_d       = S_DUMP_RD;
						end
					end
					OP_ADD, OP_SUB: begin
						if (stat.lt2) begin
							cmd.emit_status = ST_FEW;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_addr = WA_N2;
							cmd.wr_data = (op_q == OP_ADD) ? WD_SUM : WD_DIFF;
							cmd.cnt_dec = 1'b1;
						end
					end
					OP_MUL: begin
						if (stat.lt2) begin
							cmd.emit_status = ST_FEW;
						end else begin
							cmd.emit       = 1'b0;
							cmd.unit_start = 1'b1;
							state_d        = S_ITER;
						end
					end
					OP_DIV: begin
						// Empty stack first, then a zero divisor, then a lone entry.
						if (stat.empty) begin
							cmd.emit_status = ST_FEW;
						end else if (stat.top_zero) begin
							cmd.emit_status = ST_DIVZ;
						end else if (stat.lt2) begin
							cmd.emit_status = ST_FEW;
						end else begin
							cmd.emit       = 1'b0;
							cmd.unit_start = 1'b1;
							cmd.unit_div   = 1'b1;
							state_d        = S_ITER;
						end
					end
					default: begin
						// Unknown operations report plain success.
					end
				endcase
			end
			S_SWAP2: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = WA_N2;
				cmd.wr_data = WD_TOP;
				cmd.emit    = 1'b1;
				state_d     = S_IDLE;
			end
			S_ITER: begin
				if (stat.unit_done) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = WA_N2;
					cmd.wr_data = WD_UNIT;
					cmd.cnt_dec = 1'b1;
					cmd.emit    = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_DUMP_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_walk = 1'b1;
				state_d     = S_DUMP_OUT;
			end
			S_DUMP_OUT: begin
				cmd.emit      = 1'b1;
				cmd.emit_has  = 1'b1;
				cmd.emit_last = stat.walk_zero;
				if (stat.walk_zero) begin
					state_d = S_IDLE;
				end else begin
					cmd.walk_dec = 1'b1;
					state_d      = S_DUMP_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, latched operation and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			op_q    <= OP_PUSH;
		end else begin
			state_q <= state_d;
			busy_q  <= state_d != S_IDLE;
			if (cmd.capture) begin
				op_q <= op_t'(operation);
			end
		end
	end

	assign busy = busy_q;

endmodule

`default_nettype wire

// File: hw/rtl/rpn_integer_stack_calculator.sv
// Top level of the reverse-Polish integer stack calculator.
//
//  Channel   Ports                  Handshake
//  request   start, busy, req       taken at a rising edge with start high and busy low
//  result    done, rsp              done high for one cycle; the result is taken then
//
// A request is finished before the next is taken. Simple requests and every error result
// pass a registered stack read, then the update and result; swap adds a second write.
// Multiply and divide wait for the unit, which retires one bit per cycle, before the
// update and result. Dump gives a read and a result for each entry, top first.
// Reset empties the stack at once; busy stays high while a request is in progress,
// and the receiver cannot stall the result strobe.
`default_nettype none

module rpn_integer_stack_calculator #(
	parameter int STACK_DEPTH = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire rpnc_pkg::req_t  req,
	output logic                 done,
	output rpnc_pkg::rsp_t       rsp
);

	import rpnc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencing of each request.
	rpnc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (req.operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	// Stack storage and arithmetic.
	rpnc_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// File: sim/rpnc_result_check.sv
// Predicts and checks every result of the RPN stack calculator.
`default_nettype none

module rpnc_result_check #(
	parameter int STACK_DEPTH = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           busy,
	input  wire rpnc_pkg::req_t req,
	input  wire logic           done,
	input  wire rpnc_pkg::rsp_t rsp,
	output int                  fail_count,
	output int                  pending
);

	import rpnc_pkg::*;

	// Shadow copy of the calculator state.
	logic [31:0] calc_stack [STACK_DEPTH];
	int          calc_depth;
	rsp_t        expected_results [$];
	int          errors;

	// Truncating signed division on magnitudes, so that the most negative
	// value over minus one wraps instead of overflowing.
	function automatic logic [31:0] quotient_toward_zero(input logic [31:0] a,
		input logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		if (a[31] != b[31]) begin
			q = -q;
		end
		return q;
	endfunction

	// Apply one request to the shadow stack and queue what it should produce.
	function automatic void predict_request(input req_t r);
		rsp_t        e;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] t;
		int          k;
		e = '0;
		e.status = ST_OK;
		e.last_of_run = 1'b1;
		case (r.operation)
			OP_PUSH: begin
				if (calc_depth >= STACK_DEPTH) begin
					e.status = ST_FULL;
				end else begin
					calc_stack[calc_depth] = r.operand_value;
					calc_depth++;
				end
			end
			OP_NEG: begin
				if (calc_depth < 1) begin
					e.status = ST_FEW;
				end else begin
					calc_stack[calc_depth - 1] = -calc_stack[calc_depth - 1];
				end
			end
			OP_DUP: begin
				if (calc_depth < 1) begin
					e.status = ST_FEW;
				end else if (calc_depth >= STACK_DEPTH) begin
					e.status = ST_FULL;
				end else begin
					calc_stack[calc_depth] = calc_stack[calc_depth - 1];
					calc_depth++;
				end
			end
			OP_SWAP: begin
				if (calc_depth < 2) begin
					e.status = ST_FEW;
				end else begin
					t = calc_stack[calc_depth - 1];
					calc_stack[calc_depth - 1] = calc_stack[calc_depth - 2];
					calc_stack[calc_depth - 2] = t;
				end
			end
			OP_PEEK: begin
				if (calc_depth < 1) begin
					e.status = ST_FEW;
				end else begin
					e.result_value = calc_stack[calc_depth - 1];
					e.has_value = 1'b1;
				end
			end
			OP_CLEAR: begin
				calc_depth = 0;
			end
			OP_DUMP: begin
				// A non-empty dump gives one result per entry, top first.
				if (calc_depth > 0) begin
					for (k = calc_depth - 1; k >= 0; k--) begin
						e.result_value = calc_stack[k];
						e.has_value = 1'b1;
						e.last_of_run = (k == 0);
						expected_results.push_back(e);
					end
					return;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				// Empty check, then zero divisor, then the second operand.
				if (calc_depth < 1) begin
					e.status = ST_FEW;
				end else if (r.operation == OP_DIV &&
					calc_stack[calc_depth - 1] == 0) begin
					e.status = ST_DIVZ;
				end else if (calc_depth < 2) begin
					e.status = ST_FEW;
				end else begin
					a = calc_stack[calc_depth - 2];
					b = calc_stack[calc_depth - 1];
					case (r.operation)
						OP_ADD:  t = a + b;
						OP_SUB:  t = a - b;
						OP_MUL:  t = a * b;
						default: t = quotient_toward_zero(a, b);
					endcase
					calc_stack[calc_depth - 2] = t;
					calc_depth--;
				end
			end
			default: begin
			end
		endcase
		expected_results.push_back(e);
	endfunction

	// Compare results first, then queue the request taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			calc_depth = 0;
			expected_results.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, %s %0d %0b %0d %0b",
						$time, "got value has status last", rsp.result_value,
						rsp.has_value, rsp.status, rsp.last_of_run);
				end else begin
					exp_rsp = expected_results.pop_front();
					if (rsp.result_value !== exp_rsp.result_value) begin
						errors++;
						$display("%0t: result_value expected %0d got %0d",
							$time, exp_rsp.result_value, rsp.result_value);
					end
					if (rsp.has_value !== exp_rsp.has_value) begin
						errors++;
						$display("%0t: has_value expected %0b got %0b",
							$time, exp_rsp.has_value, rsp.has_value);
					end
					if (rsp.status !== exp_rsp.status) begin
						errors++;
						$display("%0t: status expected %0d got %0d",
							$time, exp_rsp.status, rsp.status);
					end
					if (rsp.last_of_run !== exp_rsp.last_of_run) begin
						errors++;
						$display("%0t: last_of_run expected %0b got %0b",
							$time, exp_rsp.last_of_run, rsp.last_of_run);
					end
				end
			end
			if (start && !busy) begin
				predict_request(req);
			end
			fail_count <= errors;
			pending <= expected_results.size();
		end
	end

endmodule

`default_nettype wire

// File: sim/tb_rpn_integer_stack_calculator.sv
// Stimulus and verdict for the RPN stack calculator testbench.
`default_nettype none

module tb_rpn_integer_stack_calculator;
	import rpnc_pkg::*;

	localparam int          CALC_DEPTH    = 32;
	localparam int          QUIET_LIMIT   = 1000;
	localparam int          RANDOM_ITEMS  = 154;
	localparam int          MAX_GAP       = 30;
	localparam logic [3:0]  OP_UNUSED_LO  = 4'd11;
	localparam logic [3:0]  OP_UNUSED_HI  = 4'd15;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	int   fail_count;
	int   pending;
	int   idle_pct;

	rpn_integer_stack_calculator #(
		.STACK_DEPTH(CALC_DEPTH),
		.VALUE_WIDTH(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	rpnc_result_check #(
		.STACK_DEPTH(CALC_DEPTH)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Build one request.
	function automatic req_t make_request(input logic [3:0] op, input logic [31:0] value);
		req_t r;
		r.operation = op;
		r.operand_value = value;
		return r;
	endfunction

	// Operand mix: extremes, zero, small numbers for division, and full range.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(7))
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h7FFF_FFFF;
			3:       return 32'h8000_0000;
			4:       return $urandom_range(40) - 20;
			default: return $urandom;
		endcase
	endfunction

	// Weighted operation mix that keeps the stack at a useful depth.
	function automatic logic [3:0] pick_operation();
		int r;
		r = $urandom_range(99);
		if (r < 30) return OP_PUSH;
		if (r < 36) return OP_NEG;
		if (r < 42) return OP_DUP;
		if (r < 48) return OP_SWAP;
		if (r < 54) return OP_PEEK;
		if (r < 57) return OP_CLEAR;
		if (r < 61) return OP_DUMP;
		if (r < 69) return OP_ADD;
		if (r < 76) return OP_SUB;
		if (r < 84) return OP_MUL;
		if (r < 96) return OP_DIV;
		return 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
	endfunction

	// Offer one request after a random gap and hold it until it is taken.
	task automatic send_request(input req_t r);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
	endtask

	// Hold the next request back until every expected result has come.
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// One stretch of random requests, with occasional bursts that fill the stack.
	task automatic random_phase(input int items);
		int sent;
		int k;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(24) == 0) begin
				for (k = 0; k < CALC_DEPTH + 2; k++) begin
					send_request(make_request(OP_PUSH, pick_operand()));
				end
				sent += CALC_DEPTH + 2;
			end else begin
				send_request(make_request(pick_operation(), pick_operand()));
				sent++;
			end
			if ($urandom_range(29) == 0) begin
				drain_results();
			end
		end
		drain_results();
	endtask

	// Watchdog: end the run if nothing is taken on either side for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb_rpn_integer_stack_calculator: errors");
		$finish;
	end

	initial begin
		int k;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		idle_pct = 28;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Operations on an empty stack, including an empty dump.
		send_request(make_request(OP_PEEK, 32'd0));
		send_request(make_request(OP_DUMP, 32'd0));
		send_request(make_request(OP_NEG, 32'd0));
		send_request(make_request(OP_DUP, 32'd0));
		send_request(make_request(OP_ADD, 32'd0));
		send_request(make_request(OP_DIV, 32'd0));
		// Single entry: divide and swap lack an operand; then a divide by a zero top.
		send_request(make_request(OP_PUSH, 32'd7));
		send_request(make_request(OP_DIV, 32'd0));
		send_request(make_request(OP_SWAP, 32'd0));
		send_request(make_request(OP_PUSH, 32'd0));
		send_request(make_request(OP_DIV, 32'd0));
		send_request(make_request(OP_CLEAR, 32'd0));
		// Most negative over minus one wraps; then an add of the two extremes and the rest.
		send_request(make_request(OP_PUSH, 32'h8000_0000));
		send_request(make_request(OP_PUSH, 32'hFFFF_FFFF));
		send_request(make_request(OP_DIV, 32'd0));
		send_request(make_request(OP_PEEK, 32'd0));
		send_request(make_request(OP_PUSH, 32'h7FFF_FFFF));
		send_request(make_request(OP_ADD, 32'd0));
		send_request(make_request(OP_NEG, 32'd0));
		send_request(make_request(OP_PUSH, -32'sd7));
		send_request(make_request(OP_PUSH, 32'd2));
		send_request(make_request(OP_DIV, 32'd0));
		send_request(make_request(OP_DUP, 32'd0));
		send_request(make_request(OP_MUL, 32'd0));
		send_request(make_request(OP_SWAP, 32'd0));
		send_request(make_request(OP_SUB, 32'd0));
		send_request(make_request(OP_DUMP, 32'd0));
		send_request(make_request(OP_UNUSED_LO, 32'hFFFF_FFFF));
		send_request(make_request(OP_UNUSED_HI, 32'd0));
		// Fill the stack, then push and duplicate onto it while full.
		send_request(make_request(OP_CLEAR, 32'd0));
		for (k = 0; k < CALC_DEPTH; k++) begin
			send_request(make_request(OP_PUSH, pick_operand()));
		end
		send_request(make_request(OP_PUSH, 32'd1));
		send_request(make_request(OP_DUP, 32'd0));
		send_request(make_request(OP_DUMP, 32'd0));
		send_request(make_request(OP_CLEAR, 32'd0));
		drain_results();

		// Random traffic under three idling patterns.
		idle_pct = 28;
		random_phase(RANDOM_ITEMS / 3);
		idle_pct = 51;
		random_phase(RANDOM_ITEMS / 3);
		idle_pct = 0;
		random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

		// Let any stray result show up before the verdict.
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_rpn_integer_stack_calculator: clean");
		end else begin
			$display("tb_rpn_integer_stack_calculator: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
